### design/ovl_pkg.sv
// Shared types and constants for the ordered value list.
`timescale 1ns / 1ps

package ovl_pkg;

	// Number of list slots, one cell per slot
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_DUMP   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_DELETED  = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4,
		ST_LISTED   = 3'd5
	} status_t;

	// What every cell does on this clock
	typedef enum logic [2:0] {
		CC_HOLD,
		CC_APPEND,
		CC_INSERT,
		CC_DELETE,
		CC_ROTATE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t          cmd;
		logic [CNT_W-1:0]   occ;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} ctrl_state_t;

endpackage

### design/ovl_cell.sv
// One list slot: holds a value and moves it to or from its neighbors.
`timescale 1ns / 1ps

module ovl_cell (
	input  logic                             clk,
	input  logic [ovl_pkg::IDX_W-1:0]        idx,
	input  ovl_pkg::cell_ctl_t               ctl,
	input  logic signed [ovl_pkg::VAL_W-1:0] operand,
	input  logic signed [ovl_pkg::VAL_W-1:0] left_val,
	input  logic signed [ovl_pkg::VAL_W-1:0] right_val,
	input  logic signed [ovl_pkg::VAL_W-1:0] head_val,
	input  logic                             match_in,
	output logic                             match_out,
	output logic signed [ovl_pkg::VAL_W-1:0] value
);
	import ovl_pkg::*;

	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] value_d;
	logic                    in_list;
	logic                    is_tail;
	logic                    match_here;

	assign in_list    = CNT_W'(idx) < ctl.occ;
	assign is_tail    = (CNT_W'(idx) + CNT_W'(1)) == ctl.occ;
	assign match_here = in_list && (value_q == operand);
	// At or past the first match in the list
	assign match_out  = match_in || match_here;
	assign value      = value_q;

	// Next value of this slot
	always_comb begin
		value_d = value_q;
		unique case (ctl.cmd)
			CC_HOLD:   value_d = value_q;
			CC_APPEND: if (CNT_W'(idx) == ctl.occ) value_d = operand;
			CC_INSERT: value_d = left_val;
			CC_DELETE: if (match_out) value_d = right_val;
			CC_ROTATE: value_d = is_tail ? head_val : right_val;
			default:   value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

### design/ovl_ctrl.sv
// Command decode, occupancy count, dump sequencing and result register.
`timescale 1ns / 1ps

module ovl_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic                             found,
	input  logic signed [ovl_pkg::VAL_W-1:0] head_val,
	output ovl_pkg::cell_ctl_t               ctl,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic signed [ovl_pkg::VAL_W-1:0] element,
	output logic                             last
);
	import ovl_pkg::*;

	ctrl_state_t             state_q, state_d;
	logic [CNT_W-1:0]        occ_q, occ_d;
	logic [CNT_W-1:0]        pos_q, pos_d;
	logic                    out_vld_q;
	status_t                 status_q, status_d;
	logic signed [VAL_W-1:0] element_q, element_d;
	logic                    last_q, last_d;
	logic                    load;
	logic                    take;
	logic                    accept;
	logic                    full;
	logic                    empty;
	cell_cmd_t               cmd;

	assign take     = !out_vld_q || out_ready;
	assign in_ready = (state_q == S_IDLE) && take;
	assign accept   = in_valid && in_ready;
	assign full     = occ_q == CNT_W'(CAPACITY);
	assign empty    = occ_q == '0;

	assign ctl.cmd  = cmd;
	assign ctl.occ  = occ_q;

	// Next state, cell command and result
	always_comb begin
		state_d   = state_q;
		occ_d     = occ_q;
		pos_d     = pos_q;
		cmd       = CC_HOLD;
		load      = 1'b0;
		status_d  = status_q;
		element_d = '0;
		last_d    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					load = 1'b1;
					unique case (opcode_t'(opcode))
						OP_APPEND, OP_INSERT: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								cmd      = (opcode_t'(opcode) == OP_APPEND) ? CC_APPEND
								                                            : CC_INSERT;
								occ_d    = occ_q + CNT_W'(1);
								status_d = ST_ADDED;
							end
						end
						OP_DELETE: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else if (found) begin
								cmd      = CC_DELETE;
								occ_d    = occ_q - CNT_W'(1);
								status_d = ST_DELETED;
							end else begin
								status_d = ST_NOTFOUND;
							end
						end
						OP_DUMP: begin
							if (empty) begin
								status_d = ST_EMPTY;
							end else begin
								// First entry goes out now, the rest in S_DUMP
								cmd       = CC_ROTATE;
								status_d  = ST_LISTED;
								element_d = head_val;
								last_d    = occ_q == CNT_W'(1);
								pos_d     = CNT_W'(1);
								if (occ_q != CNT_W'(1)) state_d = S_DUMP;
							end
						end
						default: status_d = ST_EMPTY;
					endcase
				end
			end
			S_DUMP: begin
				if (take) begin
					load      = 1'b1;
					cmd       = CC_ROTATE;
					status_d  = ST_LISTED;
					element_d = head_val;
					last_d    = pos_q == (occ_q - CNT_W'(1));
					pos_d     = pos_q + CNT_W'(1);
					if (last_d) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			occ_q   <= occ_d;
			pos_q   <= pos_d;
			if (load) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q  <= status_d;
			element_q <= element_d;
			last_q    <= last_d;
		end
	end

	assign out_valid = out_vld_q;
	assign status    = status_q;
	assign element   = element_q;
	assign last      = last_q;

endmodule

### design/ordered_value_list_top.sv
// Top level: controller plus a row of list cells.
// Append, insert and delete: one item per cycle unless the result output stalls; results are registered.
// Dump of N entries: N results, one per cycle unless the result output stalls; the list rotates through cell 0.
// A new item is taken only once the last result of a dump has been loaded.
// Reset (arst_n low) empties the list and drops any pending result; cell
// contents are not cleared and are only read below the occupancy count.
`timescale 1ns / 1ps

module ordered_value_list_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic signed [ovl_pkg::VAL_W-1:0] operand,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [2:0]                       status,
	output logic signed [ovl_pkg::VAL_W-1:0] element,
	output logic                             last
);
	import ovl_pkg::*;

	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] vals [CAPACITY];
	logic [CAPACITY:0]       match_chain;

	assign match_chain[0] = 1'b0;

	ovl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.found    (match_chain[CAPACITY]),
		.head_val (vals[0]),
		.ctl      (ctl),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.element  (element),
		.last     (last)
	);

	// Row of cells, slot 0 is the head of the list
	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic signed [VAL_W-1:0] left_v;
		logic signed [VAL_W-1:0] right_v;

		if (k == 0) begin : g_head
			assign left_v = operand;
		end else begin : g_body
			assign left_v = vals[k-1];
		end

		if (k == CAPACITY - 1) begin : g_end
			assign right_v = vals[k];
		end else begin : g_mid
			assign right_v = vals[k+1];
		end

		ovl_cell u_cell (
			.clk      (clk),
			.idx      (IDX_W'(k)),
			.ctl      (ctl),
			.operand  (operand),
			.left_val (left_v),
			.right_val(right_v),
			.head_val (vals[0]),
			.match_in (match_chain[k]),
			.match_out(match_chain[k+1]),
			.value    (vals[k])
		);
	end

endmodule

### design/ovl_checker.sv
// Port-level checks for the ordered value list, bound to the top level.
`timescale 1ns / 1ps

module ovl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [2:0]                       status,
	input logic signed [ovl_pkg::VAL_W-1:0] element,
	input logic                             last
);
	import ovl_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(element)
		&& $stable(last))
		else $error("stalled result changed");

	// No new item while the result register is blocked
	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken with result register full");

	// Every accepted item produces a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item gave no result");

	// Non-listing results are single and carry a zero element
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_LISTED) |-> last && (element == '0))
		else $error("bad non-listing result");

endmodule

bind ordered_value_list_top ovl_checker u_ovl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status   (status),
	.element  (element),
	.last     (last)
);

### verif/ordered_value_list_top_test.sv
// Self-checking testbench for ordered_value_list_top: random and directed list commands.
`timescale 1ns / 1ps

module ordered_value_list_top_test;
	import ovl_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 305;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 150;

	typedef struct packed {
		status_t                 status;
		logic signed [VAL_W-1:0] element;
		logic                    last;
	} list_result_t;

	// Tracks list contents and the results each accepted command should produce
	class list_tracker;
		logic signed [VAL_W-1:0] slots [CAPACITY];
		int                      fill;
		list_result_t            awaited [$];
		int                      errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		function void push_result(status_t st, logic signed [VAL_W-1:0] val, logic fin);
			list_result_t r;
			r.status  = st;
			r.element = val;
			r.last    = fin;
			awaited.push_back(r);
		endfunction

		// Apply one accepted command to the tracked list
		function void note_command(opcode_t op, logic signed [VAL_W-1:0] val);
			int pos;
			case (op)
				OP_APPEND, OP_INSERT: begin
					if (fill >= CAPACITY) begin
						push_result(ST_FULL, '0, 1'b1);
					end else begin
						if (op == OP_APPEND) begin
							slots[fill] = val;
						end else begin
							for (pos = fill; pos > 0; pos--)
								slots[pos] = slots[pos-1];
							slots[0] = val;
						end
						fill++;
						push_result(ST_ADDED, '0, 1'b1);
					end
				end
				OP_DELETE: begin
					if (fill == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						pos = 0;
						while (pos < fill && slots[pos] != val)
							pos++;
						if (pos >= fill) begin
							push_result(ST_NOTFOUND, '0, 1'b1);
						end else begin
							// later entries close up
							for (; pos + 1 < fill; pos++)
								slots[pos] = slots[pos+1];
							fill--;
							push_result(ST_DELETED, '0, 1'b1);
						end
					end
				end
				default: begin
					if (fill == 0) begin
						push_result(ST_EMPTY, '0, 1'b1);
					end else begin
						for (pos = 0; pos < fill; pos++)
							push_result(ST_LISTED, slots[pos], (pos + 1 == fill));
					end
				end
			endcase
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(logic [2:0] st, logic signed [VAL_W-1:0] val, logic fin);
			list_result_t want;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result status=%0d element=%0d last=%0b",
					$time, st, val, fin);
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, st);
			end
			if (val !== want.element) begin
				errors++;
				$display("%0t: element expected %0d actual %0d", $time, want.element, val);
			end
			if (fin !== want.last) begin
				errors++;
				$display("%0t: last expected %0b actual %0b", $time, want.last, fin);
			end
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [1:0]              opcode    = '0;
	logic signed [VAL_W-1:0] operand   = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [2:0]              status;
	logic signed [VAL_W-1:0] element;
	logic                    last;

	list_tracker list_board = new();
	int          results_taken = 0;
	int          cycle_count   = 0;
	bit          steady_sender = 1'b0;

	ordered_value_list_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.operand   (operand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.element   (element),
		.last      (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ordered_value_list_top_test failed");
			$finish;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			list_board.check_result(status, element, last);
			results_taken++;
		end
	end

	// Result receiver: random stalls, calm stretches, one long hold-off
	initial begin
		int gap;
		int hold;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && results_taken >= 80) begin
				held = 1'b1;
				for (hold = 0; hold < HOLD_CYCLES; hold++) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
			gap = ((results_taken / 50) % 4 == 2) ? 0 : $urandom_range(0, 9);
			repeat (gap) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Offer one command and wait until the block takes it
	task automatic send_command(input opcode_t op, input logic signed [VAL_W-1:0] val);
		int gap;
		gap = steady_sender ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		opcode   <= op;
		operand  <= val;
		do @(posedge clk); while (!in_ready);
		list_board.note_command(op, val);
	endtask

	// Small values repeat often so duplicates and matches occur
	function automatic logic signed [VAL_W-1:0] pick_operand();
		logic signed [VAL_W-1:0] v;
		case ($urandom_range(0, 9))
			0:       v = 32'sh7FFF_FFFF;
			1:       v = 32'sh8000_0000;
			2, 3, 4: v = $urandom_range(0, 6) - 3;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	initial begin
		int      k;
		int      roll;
		bit      growing;
		opcode_t op;
		logic signed [VAL_W-1:0] val;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty-list cases, extremes, duplicates, first-match delete, miss
		send_command(OP_DUMP, 32'sh5A5A_5A5A);
		send_command(OP_DELETE, 32'sd0);
		send_command(OP_APPEND, 32'sh7FFF_FFFF);
		send_command(OP_INSERT, 32'sh8000_0000);
		send_command(OP_APPEND, 32'sd0);
		send_command(OP_INSERT, -32'sd1);
		send_command(OP_APPEND, -32'sd1);
		send_command(OP_DUMP, 32'sd0);
		send_command(OP_DELETE, -32'sd1);
		send_command(OP_DELETE, 32'sh1234_5678);
		send_command(OP_DELETE, 32'sh7FFF_FFFF);

		// Fill to capacity, then push into a full list and dump it whole
		k = 0;
		while (list_board.fill < CAPACITY) begin
			send_command((k % 2) ? OP_INSERT : OP_APPEND, $urandom);
			k++;
		end
		send_command(OP_APPEND, 32'sd7);
		send_command(OP_INSERT, 32'sd7);
		send_command(OP_DUMP, 32'sd0);

		// Random part: grow to full, shrink to empty, with some noise
		growing = 1'b0;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			steady_sender = ((k / 40) % 3 == 1);
			if ($urandom_range(0, 9) == 0) begin
				op  = opcode_t'($urandom_range(0, 3));
				val = $urandom;
			end else begin
				roll = $urandom_range(0, 99);
				if (growing)
					op = (roll < 40) ? OP_APPEND : (roll < 75) ? OP_INSERT :
						(roll < 88) ? OP_DELETE : OP_DUMP;
				else
					op = (roll < 10) ? OP_APPEND : (roll < 15) ? OP_INSERT :
						(roll < 85) ? OP_DELETE : OP_DUMP;
				val = pick_operand();
				if (op == OP_DELETE && list_board.fill > 0 && $urandom_range(0, 3) != 0)
					val = list_board.slots[$urandom_range(0, list_board.fill - 1)];
			end
			send_command(op, val);
			if (growing && list_board.fill == CAPACITY && $urandom_range(0, 2) == 0)
				growing = 1'b0;
			else if (!growing && list_board.fill == 0 && $urandom_range(0, 1) == 0)
				growing = 1'b1;
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain, then keep watching for stray results
		while (list_board.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (list_board.errors == 0 && list_board.awaited.size() == 0)
			$display("ordered_value_list_top_test passed");
		else
			$display("ordered_value_list_top_test failed");
		$finish;
	end

endmodule
